FILE: sv/tmac_pkg.sv
package tmac_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxTile    = 64;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned SearchSteps = 127;

  localparam logic [6:0] NoChar = 7'd32;

  localparam logic [6:0]  TileReset   = 7'd5;
  localparam logic [5:0]  SkipReset   = 6'd0;
  localparam logic [10:0] WidthReset  = 11'd640;
  localparam logic [12:0] HeightReset = 13'd480;

  localparam int unsigned SumW = 20;
  localparam int unsigned CharW = 7;

  typedef enum logic [1:0] {
    REG_TILE   = 2'd0,
    REG_SKIP   = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

  localparam logic OpPixel = 1'b0;
  localparam logic OpTable = 1'b1;

  // Request from the tile front end to the quantizer.
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [12:0]     count;
    logic            eol;
  } tile_req_t;

endpackage

FILE: sv/tile_mean_to_ascii_char.sv
// Tile-mean ASCII quantizer.
// Input channel (in_valid/in_stall): op selects a pixel beat (op 0, raster
// order) or a character table write (op 1, table_index/table_char).
// Output channel (out_valid/out_stall): one beat per finished tile with the
// chosen character and end_of_line on the last tile of a tile row.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the
// tile size, skip rows, width and height; any write restarts the frame.
// For each pixel the column sum is read from the sum memory, added, and
// written back. When a pixel ends a tile, the quantizer runs a 29-step
// serial divider and then walks the character table memory; the input
// stalls while it runs. Reset clears position, registers to their
// defaults and the table's valid bits; the sum memory needs no clearing
// since each entry is written on the first row of its band. If the
// receiver stalls, the finished result waits in an output register and
// pixels keep flowing; beyond the quantizer's own run, the input stalls
// only while a second tile's character waits for the first to be
// delivered.
module tile_mean_to_ascii_char #(
  parameter int unsigned MaxWidth = tmac_pkg::MaxWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  pixel,
  input  logic [7:0]  table_index,
  input  logic [6:0]  table_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  character,
  output logic        end_of_line,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int unsigned AW = $clog2(MaxWidth);

  typedef enum logic [1:0] {P_IDLE, P_READ, P_WRITE} pstate_t;

  pstate_t pstate;
  logic [6:0]  tile_size;
  logic [5:0]  row_skip;
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [12:0] row_position;
  logic [11:0] column_position;
  logic [7:0]  band_phase;
  logic [6:0]  col_off;
  logic [AW-1:0] tile_col;
  logic [7:0]  pix_q;
  logic        quant_busy;
  logic        req_valid;
  tmac_pkg::tile_req_t req;

  logic [6:0]  t_eff;
  logic [12:0] w_eff;
  logic [12:0] h_eff;
  logic [7:0]  period;

  always_comb begin
    t_eff = (tile_size == 7'd0) ? 7'd1 :
            (32'(tile_size) > tmac_pkg::MaxTile) ? 7'(tmac_pkg::MaxTile) : tile_size;
    w_eff = (image_width == 11'd0) ? 13'd1 :
            (32'(image_width) > MaxWidth) ? 13'(MaxWidth) : 13'(image_width);
    h_eff = (image_height == 13'd0) ? 13'd1 :
            (32'(image_height) > 32'(tmac_pkg::MaxHeight)) ?
            13'(tmac_pkg::MaxHeight) : image_height;
    period = 8'(t_eff) + 8'(row_skip);
  end

  logic sum_we;
  logic [tmac_pkg::SumW-1:0] sum_rd, sum_new;
  logic first_pix;
  logic last_row, last_col;

  tmac_ram #(.Width(tmac_pkg::SumW), .Depth(MaxWidth)) u_sums (
    .clk(clk), .we(sum_we), .waddr(tile_col), .wdata(sum_new),
    .raddr(tile_col), .rdata(sum_rd)
  );

  assign first_pix = (band_phase == 8'd0) && (col_off == 7'd0);
  assign sum_new = first_pix ? tmac_pkg::SumW'(pix_q) : sum_rd + tmac_pkg::SumW'(pix_q);
  assign sum_we = (pstate == P_WRITE) && (band_phase < 8'(t_eff));
  assign last_row = (band_phase == 8'(t_eff) - 8'd1) ||
                    (row_position == h_eff - 13'd1);
  assign last_col = (col_off == t_eff - 7'd1) ||
                    (column_position == 12'(w_eff) - 12'd1);

  assign req_valid = sum_we && last_row && last_col;
  assign req.sum = sum_new;
  assign req.count = 13'(7'(band_phase) + 7'd1) * 13'(col_off + 7'd1);
  assign req.eol = (column_position == 12'(w_eff) - 12'd1);

  assign in_stall = (pstate != P_IDLE) || quant_busy;
  assign cfg_ready = (pstate == P_IDLE) && !quant_busy;

  tmac_quant u_quant (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req(req),
    .busy(quant_busy),
    .tbl_we(in_valid && !in_stall && op == tmac_pkg::OpTable),
    .tbl_waddr(table_index), .tbl_wdata(table_char),
    .res_valid(out_valid), .res_char(character), .res_eol(end_of_line),
    .res_take(out_valid && !out_stall)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= P_IDLE;
      tile_size <= tmac_pkg::TileReset;
      row_skip <= tmac_pkg::SkipReset;
      image_width <= tmac_pkg::WidthReset;
      image_height <= tmac_pkg::HeightReset;
      row_position <= '0;
      column_position <= '0;
      band_phase <= '0;
      col_off <= '0;
      tile_col <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (tmac_pkg::reg_idx_t'(cfg_index))
          tmac_pkg::REG_TILE:   tile_size <= cfg_data[6:0];
          tmac_pkg::REG_SKIP:   row_skip <= cfg_data[5:0];
          tmac_pkg::REG_WIDTH:  image_width <= cfg_data[10:0];
          tmac_pkg::REG_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
        row_position <= '0;
        column_position <= '0;
        band_phase <= '0;
        col_off <= '0;
        tile_col <= '0;
      end
      unique case (pstate)
        P_IDLE: if (in_valid && !in_stall && op == tmac_pkg::OpPixel) begin
          pix_q <= pixel;
          // Out-of-range position after a shrink restarts the frame.
          if (row_position >= h_eff || column_position >= 12'(w_eff) ||
              band_phase >= period || col_off >= t_eff) begin
            row_position <= '0;
            column_position <= '0;
            band_phase <= '0;
            col_off <= '0;
            tile_col <= '0;
          end
          pstate <= P_READ;
        end
        P_READ: pstate <= P_WRITE;
        P_WRITE: begin
          pstate <= P_IDLE;
          if (column_position + 12'd1 >= 12'(w_eff)) begin
            column_position <= '0;
            col_off <= '0;
            tile_col <= '0;
            if (row_position + 13'd1 >= h_eff) begin
              row_position <= '0;
              band_phase <= '0;
            end else begin
              row_position <= row_position + 13'd1;
              band_phase <= (band_phase + 8'd1 >= period) ? 8'd0 : band_phase + 8'd1;
            end
          end else begin
            column_position <= column_position + 12'd1;
            if (col_off + 7'd1 >= t_eff) begin
              col_off <= '0;
              tile_col <= tile_col + AW'(1);
            end else col_off <= col_off + 7'd1;
          end
        end
        default: pstate <= P_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    pstate != P_IDLE |-> !cfg_ready)
    else $error("config ready mid pixel");
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid |-> !quant_busy)
    else $error("tile finished while quantizer busy");
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    pstate == P_WRITE |-> col_off < t_eff)
    else $error("column offset out of tile");
`endif

endmodule

FILE: sv/tmac_ram.sv
module tmac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tmac_quant.sv
// Turns a finished tile sum into a character: a restoring divider gives
// floor(sum*256/(count*255)), then the character table is walked outward.
// The chosen character is handed to an output register, so the quantizer
// is free for the next tile while the receiver holds the previous one.
module tmac_quant (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  tmac_pkg::tile_req_t req,
  output logic                busy,
  input  logic                tbl_we,
  input  logic [7:0]          tbl_waddr,
  input  logic [6:0]          tbl_wdata,
  output logic                res_valid,
  output logic [6:0]          res_char,
  output logic                res_eol,
  input  logic                res_take
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_UP, S_UPCHK, S_DN, S_DNCHK, S_OUT
  } state_t;

  state_t state;
  logic [28:0] rem;      // partial remainder
  logic [20:0] divisor;  // count*255
  logic [28:0] quo;
  logic [4:0]  bitn;
  logic [7:0]  level;
  logic [6:0]  step;
  logic        eol;
  logic [6:0]  hit_char;
  logic [255:0] valid_bits;
  logic [7:0]  raddr;
  logic [6:0]  rdata;
  logic [8:0]  up_pos;
  logic signed [9:0] dn_pos;

  tmac_ram #(.Width(7), .Depth(tmac_pkg::TableDepth)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign up_pos = {1'b0, level} + {2'b0, step};
  assign dn_pos = $signed({2'b0, level}) - $signed({3'b0, step});

  always_comb begin
    raddr = 8'd0;
    if (state == S_UP) raddr = up_pos[7:0];
    if (state == S_DN) raddr = dn_pos[7:0];
  end

  assign busy = (state != S_IDLE);

  // Long division: rem holds the partial remainder; quo shifts the dividend out at the top.
  logic [28:0] sh_rem;
  logic [28:0] dvd;
  always_comb begin
    sh_rem = {rem[27:0], quo[28]};
    dvd = 29'(divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid_bits <= '0;
      res_valid <= 1'b0;
    end else begin
      if (tbl_we) valid_bits[tbl_waddr] <= 1'b1;
      unique case (state)
        S_IDLE: if (req_valid) begin
          rem <= '0;
          quo <= {1'b0, req.sum, 8'd0};
          divisor <= 21'(req.count) * 21'd255;
          eol <= req.eol;
          bitn <= 5'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (sh_rem >= dvd) rem <= sh_rem - dvd;
          else rem <= sh_rem;
          quo <= {quo[27:0], (sh_rem >= dvd)};
          bitn <= bitn + 5'd1;
          if (bitn == 5'd28) begin
            step <= 7'd0;
            state <= S_UP;
          end
        end
        S_UP: begin
          if (up_pos[8]) state <= S_DN;
          else state <= S_UPCHK;
        end
        S_UPCHK: begin
          if (valid_bits[up_pos[7:0]] && rdata != 7'd0) begin
            hit_char <= rdata;
            state <= S_OUT;
          end else state <= S_DN;
        end
        S_DN: begin
          if (dn_pos < 0) begin
            if (step == 7'(tmac_pkg::SearchSteps - 1)) begin
              hit_char <= tmac_pkg::NoChar;
              state <= S_OUT;
            end else begin
              step <= step + 7'd1;
              state <= S_UP;
            end
          end else state <= S_DNCHK;
        end
        S_DNCHK: begin
          if (valid_bits[dn_pos[7:0]] && rdata != 7'd0) begin
            hit_char <= rdata;
            state <= S_OUT;
          end else if (step == 7'(tmac_pkg::SearchSteps - 1)) begin
            hit_char <= tmac_pkg::NoChar;
            state <= S_OUT;
          end else begin
            step <= step + 7'd1;
            state <= S_UP;
          end
        end
        S_OUT: if (!res_valid || res_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      // The output register takes a new character once the previous one has
      // been delivered.
      if (state == S_OUT && (!res_valid || res_take)) begin
        res_valid <= 1'b1;
        res_char <= hit_char;
        res_eol <= eol;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
      if (state == S_DIV && bitn == 5'd28) begin
        // final quotient bit computed this cycle; clamp to 255
        if ({quo[27:0], (sh_rem >= dvd)} > 29'd255) level <= 8'd255;
        else level <= 8'({quo[6:0], (sh_rem >= dvd)});
      end
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_take |=> res_valid && $stable(res_char))
    else $error("result changed while held");
  a_busy_req: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req_valid)
    else $error("tile request while quantizer busy");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP) |-> step < 7'd127)
    else $error("search overran");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Ports of the block under test.
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = tmac_pkg::OpPixel;
  logic [7:0]  pixel = '0;
  logic [7:0]  table_index = '0;
  logic [6:0]  table_char = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  character;
  logic        end_of_line;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  tile_mean_to_ascii_char dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .pixel(pixel), .table_index(table_index), .table_char(table_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .character(character), .end_of_line(end_of_line),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // One input beat as queued for the driver.
  typedef struct packed {
    logic       op;
    logic [7:0] pixel;
    logic [7:0] tindex;
    logic [6:0] tchar;
  } beat_t;

  typedef struct packed {
    logic [6:0] character;
    logic       eol;
  } tile_out_t;

  beat_t     pending_beats[$];
  tile_out_t expected_tiles[$];

  // Predictor state: its own copy of the configuration, table and position.
  logic [6:0]  p_tile;
  logic [5:0]  p_skip;
  logic [10:0] p_width;
  logic [12:0] p_height;
  logic [6:0]  glyph_table[tmac_pkg::TableDepth];
  int unsigned col_sums[tmac_pkg::MaxWidth];
  int unsigned row_pos, col_pos, phase;

  int unsigned mismatches = 0;
  int unsigned tiles_seen = 0;
  int unsigned beats_sent = 0;
  bit          driver_paused = 1'b0;
  bit          calm_stretch = 1'b0;

  function automatic int unsigned clamp_range(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Nearest non-empty table slot, looking up before down at each distance.
  function automatic logic [6:0] nearest_glyph(int level);
    for (int s = 0; s < tmac_pkg::SearchSteps; s++) begin
      if (level + s < tmac_pkg::TableDepth && glyph_table[level + s] != 0)
        return glyph_table[level + s];
      if (level - s >= 0 && glyph_table[level - s] != 0)
        return glyph_table[level - s];
    end
    return tmac_pkg::NoChar;
  endfunction

  // Applies one accepted beat to the predictor and queues any finished tile.
  task automatic predict_beat(beat_t b);
    int unsigned t, w, h, period, col_off, idx;
    longint unsigned cnt, level;
    bit last_row, last_col;
    tile_out_t r;
    t = clamp_range(p_tile, tmac_pkg::MaxTile);
    w = clamp_range(p_width, tmac_pkg::MaxWidth);
    h = clamp_range(p_height, tmac_pkg::MaxHeight);
    period = t + p_skip;
    if (b.op == tmac_pkg::OpTable) begin
      glyph_table[b.tindex] = b.tchar;
      return;
    end
    if (row_pos >= h || col_pos >= w || phase >= period) begin
      row_pos = 0; col_pos = 0; phase = 0;
    end
    if (phase < t) begin
      col_off = col_pos % t;
      idx = (col_pos / t) % tmac_pkg::MaxWidth;
      if (phase == 0 && col_off == 0) col_sums[idx] = b.pixel;
      else col_sums[idx] += b.pixel;
      last_row = (phase == t - 1) || (row_pos == h - 1);
      last_col = (col_off == t - 1) || (col_pos == w - 1);
      if (last_row && last_col) begin
        cnt = longint'(phase + 1) * longint'(col_off + 1);
        level = (longint'(col_sums[idx]) * 256) / (cnt * 255);
        if (level > 255) level = 255;
        r.character = nearest_glyph(int'(level));
        r.eol = (col_pos == w - 1);
        expected_tiles.push_back(r);
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      phase++;
      if (phase >= period) phase = 0;
      if (row_pos >= h) begin
        row_pos = 0;
        phase = 0;
      end
    end
  endtask

  // Driver: presents queued beats, idling about 28 percent of the time
  // except during the calm stretch. A beat stays put while stalled.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_beat(beat_t'{op, pixel, table_index, table_char});
        beats_sent++;
      end
      if ((in_valid && in_stall) ) begin
        // hold the stalled beat
      end else if (!driver_paused && pending_beats.size() > 0 &&
                   (calm_stretch || $urandom_range(99) >= 28)) begin
        beat_t b;
        b = pending_beats.pop_front();
        in_valid <= 1'b1;
        op <= b.op;
        pixel <= b.pixel;
        table_index <= b.tindex;
        table_char <= b.tchar;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each delivered tile against the oldest prediction and
  // stalls the output at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        tiles_seen++;
        if (expected_tiles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected tile: char %0d eol %0b", character, end_of_line);
        end else begin
          tile_out_t e;
          e = expected_tiles.pop_front();
          if (e.character !== character || e.eol !== end_of_line) begin
            mismatches++;
            if (mismatches <= 10)
              $display("tile %0d: expected char %0d eol %0b, got char %0d eol %0b",
                       tiles_seen, e.character, e.eol, character, end_of_line);
          end
        end
      end
      out_stall <= !calm_stretch && ($urandom_range(99) < 28);
    end
  end

  // Waits for the driver queue to drain and every predicted tile to arrive,
  // then lets the quantizer's longest run pass before any config write.
  task automatic drain_block();
    while (pending_beats.size() > 0 || in_valid) @(posedge clk);
    while (expected_tiles.size() > 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(tmac_pkg::reg_idx_t idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[12:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      tmac_pkg::REG_TILE:   p_tile = value[6:0];
      tmac_pkg::REG_SKIP:   p_skip = value[5:0];
      tmac_pkg::REG_WIDTH:  p_width = value[10:0];
      tmac_pkg::REG_HEIGHT: p_height = value[12:0];
      default: ;
    endcase
    row_pos = 0; col_pos = 0; phase = 0;
    @(posedge clk);
  endtask

  task automatic setup_frame(int unsigned t, int unsigned s, int unsigned w,
                             int unsigned h);
    drain_block();
    write_reg(tmac_pkg::REG_TILE, t);
    write_reg(tmac_pkg::REG_SKIP, s);
    write_reg(tmac_pkg::REG_WIDTH, w);
    write_reg(tmac_pkg::REG_HEIGHT, h);
  endtask

  function automatic beat_t pixel_beat(logic [7:0] v);
    return beat_t'{tmac_pkg::OpPixel, v, 8'($urandom), 7'($urandom)};
  endfunction

  function automatic beat_t table_beat(logic [7:0] i, logic [6:0] c);
    return beat_t'{tmac_pkg::OpTable, 8'($urandom), i, c};
  endfunction

  task automatic queue_pixels(int unsigned n, int mode);
    for (int unsigned k = 0; k < n; k++) begin
      case (mode)
        0: pending_beats.push_back(pixel_beat(8'($urandom)));
        1: pending_beats.push_back(pixel_beat(8'hFF));
        default: pending_beats.push_back(pixel_beat(8'h00));
      endcase
    end
  endtask

  initial begin
    int unsigned t, s, w, h, n;
    p_tile = tmac_pkg::TileReset;
    p_skip = tmac_pkg::SkipReset;
    p_width = tmac_pkg::WidthReset;
    p_height = tmac_pkg::HeightReset;
    foreach (glyph_table[i]) glyph_table[i] = '0;
    foreach (col_sums[i]) col_sums[i] = 0;
    row_pos = 0; col_pos = 0; phase = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: an empty table gives spaces; then sparse entries at both
    // ends of the table exercise the search in both directions.
    setup_frame(1, 0, 2, 2);
    pending_beats.push_back(pixel_beat(8'h00));
    pending_beats.push_back(pixel_beat(8'hFF));
    pending_beats.push_back(table_beat(8'd0, 7'd46));
    pending_beats.push_back(table_beat(8'd255, 7'd126));
    pending_beats.push_back(table_beat(8'd128, 7'd1));
    pending_beats.push_back(table_beat(8'd127, 7'd0));
    queue_pixels(2, 1);
    queue_pixels(2, 2);
    pending_beats.push_back(pixel_beat(8'd127));
    pending_beats.push_back(pixel_beat(8'd129));

    // Directed: clipped tiles at the right and bottom edges, skip rows,
    // and registers written as zero and, but for the height, at their largest values.
    setup_frame(3, 2, 4, 7);
    queue_pixels(28, 1);
    setup_frame(0, 63, 0, 0);
    queue_pixels(3, 0);
    setup_frame(127, 0, 2047, 2);
    queue_pixels(4, 0);

    // Fill the table with a random sparse set of characters.
    drain_block();
    for (int i = 0; i < 40; i++)
      pending_beats.push_back(table_beat(8'($urandom), 7'($urandom_range(126, 1))));

    // Random frames: mostly small geometry, a few large tiles.
    for (int ph = 0; ph < 12; ph++) begin
      t = ($urandom_range(9) == 0) ? 64 : $urandom_range(6, 1);
      s = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(2);
      w = $urandom_range(20, 1);
      h = $urandom_range(12, 1);
      if (ph == 11) begin
        t = 64; s = 0; w = 336; h = 1;
      end
      setup_frame(t, s, w, h);
      calm_stretch = (ph == 4);
      n = (ph == 11) ? 336 : 36;
      for (int unsigned k = 0; k < n; k++) begin
        if ($urandom_range(19) == 0)
          pending_beats.push_back(table_beat(8'($urandom), 7'($urandom_range(126))));
        else
          pending_beats.push_back(pixel_beat(8'($urandom)));
      end
      // The sender holds off once until every tile has come back.
      if (ph == 6) begin
        while (pending_beats.size() > 0 || in_valid) @(posedge clk);
        driver_paused = 1'b1;
        while (expected_tiles.size() > 0) @(posedge clk);
        driver_paused = 1'b0;
      end
    end
    calm_stretch = 1'b0;

    while (pending_beats.size() > 0 || in_valid) @(posedge clk);
    while (expected_tiles.size() > 0) @(posedge clk);
    repeat (700) @(posedge clk);

    $display("Ran %0d input beats over several tile, skip and frame sizes;", beats_sent);
    $display("%0d tiles were checked, %0d mismatches.", tiles_seen, mismatches);
    if (mismatches == 0 && expected_tiles.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
